@@ rtl/lps_pkg.sv @@
// shared types and constants of the five point laplacian stencil unit
package lps_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int RESULT_W   = 35;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int ROW_W      = 16;

  localparam logic [ROW_W-1:0] ROW_COUNT_MAX = {ROW_W{1'b1}};

  // item kinds on the input channel
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_FLUSH  = 1'b1
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLUMNS = 1'b0,
    REG_TOP_HALO     = 1'b1
  } cfg_reg_t;

  // one line buffer entry: row r-1 and row r-2 at the same column
  typedef struct packed {
    logic [SAMPLE_W-1:0] prv;
    logic [SAMPLE_W-1:0] rbp;
  } line_ent_t;

  // per-beat control from the sequencer to the datapath
  typedef struct packed {
    logic last;
    logic produce;
    logic use_left;
    logic use_up;
  } seq_ctl_t;

endpackage

@@ rtl/lps_in_if.sv @@
// input channel: grid samples and flush items
interface lps_in_if;
  import lps_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       op;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink   (input valid, input op, input sample, output ready);
endinterface

@@ rtl/lps_out_if.sv @@
// result channel: stencil values
interface lps_out_if;
  import lps_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] stencil_value;
  logic                       row_last;

  modport source (output valid, output stencil_value, output row_last, input ready);
  modport sink   (input valid, input stencil_value, input row_last, output ready);
endinterface

@@ rtl/lps_cfg_if.sv @@
// configuration write channel
interface lps_cfg_if;
  import lps_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/lps_line_buf.sv @@
// dual-read line buffer holding the two previous rows, with write bypass
module lps_line_buf
  import lps_pkg::*;
#(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  line_ent_t         wr_data,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output line_ent_t         rd_data_a,
  output line_ent_t         rd_data_b
);

  line_ent_t mem [DEPTH];

  line_ent_t q_a_r;
  line_ent_t q_b_r;
  line_ent_t byp_r;
  logic      hit_a_r;
  logic      hit_b_r;

  // storage write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    q_a_r <= mem[rd_addr_a];
    q_b_r <= mem[rd_addr_b];
    byp_r <= wr_data;
  end

  // same-edge read and write at one address returns the new entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_a_r <= 1'b0;
      hit_b_r <= 1'b0;
    end else begin
      hit_a_r <= we && (rd_addr_a == wr_addr);
      hit_b_r <= we && (rd_addr_b == wr_addr);
    end
  end

  assign rd_data_a = hit_a_r ? byp_r : q_a_r;
  assign rd_data_b = hit_b_r ? byp_r : q_b_r;

endmodule

@@ rtl/lps_seq.sv @@
// column and row sequencer with configuration registers
module lps_seq
  import lps_pkg::*;
#(
  parameter int MAX_COLS = 1024,
  parameter int COL_W    = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic                  flush,
  output seq_ctl_t              ctl,
  output logic [COL_W-1:0]      wr_addr,
  output logic [COL_W-1:0]      rd_addr_a,
  output logic [COL_W-1:0]      rd_addr_b,
  output logic                  rd_ok
);

  localparam int CNT_W = $clog2(MAX_COLS + 1);
  localparam int CMP_W = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_COLS);

  logic [CFG_DATA_W-1:0] grid_columns_r;
  logic                  top_halo_r;
  logic [COL_W-1:0]      col_r;
  logic [COL_W-1:0]      col_nxt;
  logic [ROW_W-1:0]      row_r;
  logic [ROW_W-1:0]      row_nxt;
  logic                  rd_ok_r;
  logic [CMP_W-1:0]      gc_ext;
  logic [CMP_W-1:0]      last_ext;
  logic [COL_W-1:0]      last_idx;
  logic [COL_W-1:0]      j;

  // last column index with the column count clamped to its range
  always_comb begin
    gc_ext = CMP_W'(grid_columns_r);
    if (gc_ext < CMP_W'(2)) begin
      last_ext = CMP_W'(1);
    end else if (gc_ext > MAX_C) begin
      last_ext = MAX_C - CMP_W'(1);
    end else begin
      last_ext = gc_ext - CMP_W'(1);
    end
    last_idx = last_ext[COL_W-1:0];
  end

  // current column, clamped after a shrink
  always_comb begin
    j            = (col_r >= last_idx) ? last_idx : col_r;
    ctl.last     = (j == last_idx);
    ctl.use_left = (j != '0);
    ctl.use_up   = (row_r >= ROW_W'(2));
    ctl.produce  = (row_r != '0) && !(top_halo_r && (row_r == ROW_W'(1)));
  end

  // next column and row
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (ctl.last) begin
        col_nxt = '0;
        if (flush) begin
          row_nxt = '0;
        end else if (row_r != ROW_COUNT_MAX) begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = j + COL_W'(1);
      end
    end
  end

  // line buffer addresses: reads aim at the column of the next beat
  assign wr_addr   = j;
  assign rd_addr_a = accept ? col_nxt : j;
  assign rd_addr_b = rd_addr_a + COL_W'(1);
  assign rd_ok     = rd_ok_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_columns_r <= CFG_DATA_W'(200);
      top_halo_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_COLUMNS: grid_columns_r <= cfg_data;
        REG_TOP_HALO:     top_halo_r     <= cfg_data[0];
        default:          grid_columns_r <= grid_columns_r;
      endcase
    end
  end

  // counters; read data is marked stale by reset and by a config write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      rd_ok_r <= !cfg_we;
    end
  end

endmodule

@@ rtl/five_point_laplacian_stencil_unit.sv @@
// top level of the five point laplacian stencil unit
//
//  channel  dir  beat contents               handshake
//  in_ch    in   op, sample (Q8.24)          valid / ready
//  out_ch   out  stencil_value (Q11.24),     valid / ready
//                row_last
//  cfg_ch   in   index, data                 valid / ready (always ready)
//
// One input beat per cycle unless the output stalls; a result is registered
// from the beat of the row below its centre. The line buffer reads at the next
// column every cycle, so its only bubbles follow reset and each config write.
// Reset is synchronous and active low; line buffer contents are not cleared.
// A stalled result holds in the output register; input is taken as long as
// that register is empty or being drained.
module five_point_laplacian_stencil_unit
  import lps_pkg::*;
#(
  parameter int MAX_COLS = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  lps_in_if.sink       in_ch,
  lps_out_if.source    out_ch,
  lps_cfg_if.sink      cfg_ch
);

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  seq_ctl_t         ctl;
  logic [COL_W-1:0] wr_addr;
  logic [COL_W-1:0] rd_addr_a;
  logic [COL_W-1:0] rd_addr_b;
  logic             rd_ok;
  logic             accept;
  logic             flush;
  logic             cfg_we;
  line_ent_t        rd_a;
  line_ent_t        rd_b;
  line_ent_t        wr_ent;

  logic signed [SAMPLE_W-1:0] cur;
  logic signed [SAMPLE_W-1:0] centre;
  logic signed [SAMPLE_W-1:0] left;
  logic signed [SAMPLE_W-1:0] right;
  logic signed [SAMPLE_W-1:0] up;
  logic signed [RESULT_W-1:0] value;

  logic signed [SAMPLE_W-1:0] left_r;
  logic                       out_vld_r;
  logic                       out_vld_nxt;
  logic signed [RESULT_W-1:0] value_r;
  logic                       last_r;

  // handshakes
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;
  assign in_ch.ready  = rd_ok && (!out_vld_r || out_ch.ready);
  assign accept       = in_ch.valid && in_ch.ready;
  assign flush        = (op_t'(in_ch.op) == OP_FLUSH);

  lps_seq #(
    .MAX_COLS (MAX_COLS),
    .COL_W    (COL_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .accept    (accept),
    .flush     (flush),
    .ctl       (ctl),
    .wr_addr   (wr_addr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_ok     (rd_ok)
  );

  lps_line_buf #(
    .DEPTH  (MAX_COLS),
    .ADDR_W (COL_W)
  ) u_line_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .we        (accept),
    .wr_addr   (wr_addr),
    .wr_data   (wr_ent),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // neighbour selection with zero beyond the grid
  always_comb begin
    cur    = flush ? '0 : in_ch.sample;
    centre = $signed(rd_a.prv);
    up     = ctl.use_up ? $signed(rd_a.rbp) : '0;
    right  = ctl.last ? '0 : $signed(rd_b.prv);
    left   = ctl.use_left ? left_r : '0;
    wr_ent.prv = cur;
    wr_ent.rbp = centre;
  end

  // 4*centre minus the four neighbours, exact in the result width
  assign value = (RESULT_W'(centre) <<< 2) - RESULT_W'(left) - RESULT_W'(right)
               - RESULT_W'(up) - RESULT_W'(cur);

  // output register valid
  always_comb begin
    if (accept) begin
      out_vld_nxt = ctl.produce;
    end else begin
      out_vld_nxt = out_vld_r && !out_ch.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  // result payload and left neighbour
  always_ff @(posedge clk) begin
    if (accept) begin
      left_r <= centre;
      if (ctl.produce) begin
        value_r <= value;
        last_r  <= ctl.last;
      end
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.stencil_value = value_r;
  assign out_ch.row_last      = last_r;

endmodule
